/* src/iir_df1_pkg.sv */
// ----------------------------------------------------------------------------
// iir_df1_pkg
// Shared types and constants of the direct-form-I IIR filter: register map,
// accumulator width and coefficient reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package iir_df1_pkg;

	// Accumulator width; sums wrap modulo 2^ACC_W.
	localparam int ACC_W = 64;

	// Configuration channel.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int HALF_W     = 32;

	// Tap count register.
	localparam int TAP_W = 3;
	localparam logic [TAP_W-1:0] TAP_RESET = 3'd1;

	// Feedforward b0 resets to 1.0 in Q4.28.
	localparam logic [HALF_W-1:0] B0_RESET = 32'h1000_0000;

	// Feedback coefficient a_l sits at index FB_BASE + l of the flat list.
	localparam int FB_BASE = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAP_COUNT,
		REG_COEF_PAIR_0,
		REG_COEF_PAIR_1,
		REG_COEF_PAIR_2,
		REG_COEF_PAIR_3,
		REG_COEF_PAIR_4,
		REG_COEF_PAIR_5,
		REG_COEF_PAIR_6
	} cfg_reg_t;

	// Register that holds coefficient j of the flat list b0..b6, a1..a6.
	function automatic cfg_reg_t coef_reg(input int j);
		return cfg_reg_t'(int'(REG_COEF_PAIR_0) + j / 2);
	endfunction

	// Bit offset of coefficient j within its register word.
	function automatic int coef_offset(input int j);
		return (j % 2) * HALF_W;
	endfunction

endpackage

`default_nettype wire

/* src/iir_direct_form_one_filter.sv */
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter
// Mono direct-form-I IIR filter with up to MAX_TAPS b and MAX_TAPS-1 a terms.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive as words on the s_axis channel and leave as words on the
// m_axis channel, one output word per input word, in order.
// Coefficients and the tap count are written over the cfg channel, which is
// always ready; write them only while no sample is in flight.
// Accepted words pass the sample line, product, sum, accumulator and output
// registers to m_axis, one word per cycle while the receiver is ready. The
// limit is the feedback loop, where y_q[0] times a1 is subtracted, rounded and
// saturated back into y_q[0]; older terms are folded in a stage before.
// When the receiver stalls, the stages fill and s_axis_tready drops once
// every stage holds a word; nothing is lost or repeated.
// Reset clears both histories, sets the tap count to one and b0 to 1.0,
// with all other coefficients zero, so the block passes samples through.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_direct_form_one_filter #(
	parameter int MAX_TAPS    = 7,
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// Fields from bit 0: sample_in.
	input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,

	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// Fields from bit 0: sample_out.
	output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,

	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [iir_df1_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [iir_df1_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import iir_df1_pkg::*;

	localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

	logic [TAP_W-1:0]              taps;
	logic signed [COEF_BITS-1:0]   b_coef [MAX_TAPS];
	logic signed [COEF_BITS-1:0]   a_coef [1:MAX_TAPS-1];
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          ff_valid;
	logic                          ff_ready;
	logic signed [ACC_W-1:0]       ff_sum;

	assign cfg_ready    = 1'b1;
	assign sample_in    = s_axis_tdata[SAMPLE_BITS-1:0];
	assign m_axis_tdata = DATA_W'($unsigned(sample_out));

	iir_df1_cfg #(
		.MAX_TAPS  (MAX_TAPS),
		.COEF_BITS (COEF_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_reg_t'(cfg_index)),
		.wr_data  (cfg_data),
		.taps     (taps),
		.b_coef   (b_coef),
		.a_coef   (a_coef)
	);

	iir_df1_ff #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_ff (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_sample (sample_in),
		.b_coef    (b_coef),
		.taps      (taps),
		.out_valid (ff_valid),
		.out_ready (ff_ready),
		.out_sum   (ff_sum)
	);

	iir_df1_fb #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_fb (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (ff_valid),
		.in_ready   (ff_ready),
		.in_sum     (ff_sum),
		.a_coef     (a_coef),
		.taps       (taps),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_sample (sample_out)
	);

endmodule

`default_nettype wire

/* src/iir_df1_cfg.sv */
// ----------------------------------------------------------------------------
// iir_df1_cfg
// Configuration register file: tap count and the feedforward and feedback
// coefficients, with the tap count clamped to the supported range.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_df1_cfg #(
	parameter int MAX_TAPS  = 7,
	parameter int COEF_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  iir_df1_pkg::cfg_reg_t                  wr_index,
	input  logic [iir_df1_pkg::CFG_DATA_W-1:0]     wr_data,
	output logic [iir_df1_pkg::TAP_W-1:0]          taps,
	output logic signed [COEF_BITS-1:0]            b_coef [MAX_TAPS],
	output logic signed [COEF_BITS-1:0]            a_coef [1:MAX_TAPS-1]
);
	import iir_df1_pkg::*;

	logic [TAP_W-1:0] tap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= TAP_RESET;
			b_coef[0] <= B0_RESET[COEF_BITS-1:0];
			for (int l = 1; l < MAX_TAPS; l++) begin
				b_coef[l] <= '0;
			end
			for (int l = 1; l < MAX_TAPS; l++) begin
				a_coef[l] <= '0;
			end
		end else if (wr_en) begin
			if (wr_index == REG_TAP_COUNT) begin
				tap_q <= wr_data[TAP_W-1:0];
			end
			for (int l = 0; l < MAX_TAPS; l++) begin
				if (wr_index == coef_reg(l)) begin
					b_coef[l] <= wr_data[coef_offset(l) +: COEF_BITS];
				end
			end
			for (int l = 1; l < MAX_TAPS; l++) begin
				if (wr_index == coef_reg(FB_BASE + l)) begin
					a_coef[l] <= wr_data[coef_offset(FB_BASE + l) +: COEF_BITS];
				end
			end
		end
	end

	// A tap count of zero behaves as one; counts above the maximum saturate.
	always_comb begin
		priority if (tap_q == '0) begin
			taps = TAP_W'(1);
		end else if (int'(tap_q) > MAX_TAPS) begin
			taps = TAP_W'(MAX_TAPS);
		end else begin
			taps = tap_q;
		end
	end

endmodule

`default_nettype wire

/* src/iir_df1_ff.sv */
// ----------------------------------------------------------------------------
// iir_df1_ff
// Feedforward path: input sample shift line, one product per tap, and the
// registered sum of the products.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_df1_ff #(
	parameter int MAX_TAPS    = 7,
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [SAMPLE_BITS-1:0]          in_sample,
	input  logic signed [COEF_BITS-1:0]            b_coef [MAX_TAPS],
	input  logic [iir_df1_pkg::TAP_W-1:0]          taps,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [iir_df1_pkg::ACC_W-1:0]   out_sum
);
	import iir_df1_pkg::*;

	localparam int PROD_W = COEF_BITS + SAMPLE_BITS;

	// x_q[0] is the newest sample, x_q[l] the sample l places back.
	logic signed [SAMPLE_BITS-1:0] x_q [MAX_TAPS];
	logic                          v_s1;
	logic signed [ACC_W-1:0]       prod_s2 [MAX_TAPS];
	logic                          v_s2;
	logic signed [ACC_W-1:0]       sum_s3;
	logic                          v_s3;

	logic signed [PROD_W-1:0]      ff_prod [MAX_TAPS];
	logic signed [ACC_W-1:0]       ff_sum;
	logic                          rdy_s1;
	logic                          rdy_s2;
	logic                          rdy_s3;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		for (int l = 0; l < MAX_TAPS; l++) begin
			ff_prod[l] = b_coef[l] * x_q[l];
		end
	end

	always_comb begin
		ff_sum = '0;
		for (int l = 0; l < MAX_TAPS; l++) begin
			ff_sum = ff_sum + prod_s2[l];
		end
	end

	// The sample line is both the input history and the first stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < MAX_TAPS; l++) begin
				x_q[l] <= '0;
			end
			v_s1 <= 1'b0;
		end else begin
			if (in_valid && rdy_s1) begin
				x_q[0] <= in_sample;
				for (int l = 1; l < MAX_TAPS; l++) begin
					x_q[l] <= x_q[l-1];
				end
			end
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			for (int l = 0; l < MAX_TAPS; l++) begin
				if (l < int'(taps)) begin
					prod_s2[l] <= ACC_W'(ff_prod[l]);
				end else begin
					prod_s2[l] <= '0;
				end
			end
		end
		if (v_s2 && rdy_s3) begin
			sum_s3 <= ff_sum;
		end
	end

	assign out_valid = v_s3;
	assign out_sum   = sum_s3;

	a_sample_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (x_q[0] == $past(in_sample)) && v_s1)
		else $error("accepted sample did not enter the sample line");

	a_sum_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !out_ready) |=> (v_s3 && $stable(sum_s3)))
		else $error("feedforward sum changed while the feedback stage was busy");

endmodule

`default_nettype wire

/* src/iir_df1_fb.sv */
// ----------------------------------------------------------------------------
// iir_df1_fb
// Feedback path: older feedback terms are folded into the partial sum, the
// newest term closes the loop, then rounding, saturation, output history
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_df1_fb #(
	parameter int MAX_TAPS    = 7,
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [iir_df1_pkg::ACC_W-1:0]   in_sum,
	input  logic signed [COEF_BITS-1:0]            a_coef [1:MAX_TAPS-1],
	input  logic [iir_df1_pkg::TAP_W-1:0]          taps,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [SAMPLE_BITS-1:0]          out_sample
);
	import iir_df1_pkg::*;

	localparam int YW      = SAMPLE_BITS + 8;
	localparam int HIST    = MAX_TAPS - 1;
	localparam int PROD_W  = COEF_BITS + YW;
	localparam int Y_SHIFT = COEF_BITS - 12;
	localparam int O_SHIFT = COEF_BITS - 4;
	localparam logic signed [ACC_W-1:0] Y_HALF = ACC_W'(1) << (Y_SHIFT - 1);
	localparam logic signed [ACC_W-1:0] O_HALF = ACC_W'(1) << (O_SHIFT - 1);
	localparam logic signed [ACC_W-1:0] Y_HI = {{(ACC_W-YW+1){1'b0}}, {(YW-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] Y_LO = ~Y_HI;
	localparam logic signed [ACC_W-1:0] O_HI =
		{{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] O_LO = ~O_HI;

	// y_q[0] is the newest output in Q.8, y_q[l] the output l places back.
	logic signed [YW-1:0]          y_q [HIST];
	logic signed [ACC_W-1:0]       acc_s4;
	logic                          v_s4;
	logic signed [SAMPLE_BITS-1:0] out_q;
	logic                          out_valid_q;

	logic                          rdy_o;
	logic                          rdy_s4;
	logic                          fire_s4;
	logic signed [ACC_W-1:0]       part_next;
	logic signed [YW-1:0]          y_next;
	logic signed [SAMPLE_BITS-1:0] o_next;

	assign rdy_o    = !out_valid_q || out_ready;
	assign rdy_s4   = !v_s4 || rdy_o;
	assign in_ready = rdy_s4;
	assign fire_s4  = v_s4 && rdy_o;

	// Terms two or more outputs back. When a sample enters this stage while
	// the one before it is still here, that sample's output is not yet in
	// the history, so the entries sit one place nearer.
	always_comb begin
		logic signed [YW-1:0]     y_sel;
		logic signed [PROD_W-1:0] prod;
		logic signed [ACC_W-1:0]  part;
		part = in_sum;
		for (int l = 2; l < MAX_TAPS; l++) begin
			y_sel = v_s4 ? y_q[l-2] : y_q[l-1];
			prod  = a_coef[l] * y_sel;
			if (l < int'(taps)) begin
				part = part - (ACC_W'(prod) >>> 8);
			end
		end
		part_next = part;
	end

	// Newest feedback term, rounding and saturation.
	always_comb begin
		logic signed [PROD_W-1:0] prod1;
		logic signed [ACC_W-1:0]  acc;
		logic signed [ACC_W-1:0]  y_rnd;
		logic signed [ACC_W-1:0]  o_rnd;
		prod1 = a_coef[1] * y_q[0];
		acc   = acc_s4;
		if (int'(taps) > 1) begin
			acc = acc - (ACC_W'(prod1) >>> 8);
		end
		y_rnd = (acc + Y_HALF) >>> Y_SHIFT;
		o_rnd = (acc + O_HALF) >>> O_SHIFT;
		priority if (y_rnd > Y_HI) begin
			y_next = Y_HI[YW-1:0];
		end else if (y_rnd < Y_LO) begin
			y_next = Y_LO[YW-1:0];
		end else begin
			y_next = y_rnd[YW-1:0];
		end
		priority if (o_rnd > O_HI) begin
			o_next = O_HI[SAMPLE_BITS-1:0];
		end else if (o_rnd < O_LO) begin
			o_next = O_LO[SAMPLE_BITS-1:0];
		end else begin
			o_next = o_rnd[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < HIST; l++) begin
				y_q[l] <= '0;
			end
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire_s4) begin
				y_q[0] <= y_next;
				for (int l = 1; l < HIST; l++) begin
					y_q[l] <= y_q[l-1];
				end
			end
			if (rdy_s4) begin
				v_s4 <= in_valid;
			end
			if (rdy_o) begin
				out_valid_q <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s4) begin
			acc_s4 <= part_next;
		end
		if (fire_s4) begin
			out_q <= o_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_q;

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s4 |=> out_valid_q)
		else $error("finished sample did not reach the output register");

	a_history_still: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s4 |=> $stable(y_q[0]))
		else $error("output history moved without a finished sample");

endmodule

`default_nettype wire
